[rtl/tplq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplq_pkg
// Shared types and codes of the three-level priority ticket queue.
// ----------------------------------------------------------------------------
package tplq_pkg;

  localparam int IdW     = 31;
  localparam int LevelW  = 2;
  localparam int StatusW = 3;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_CHANGE   = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_PROCESS  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_BADLEVEL = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_DISPATCH,
    S_REG,
    S_UNLINK,
    S_APPEND,
    S_PROC,
    S_PROC_RD,
    S_PROC_POP,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic srch_init;  // start walk at head of current level
    logic srch_rd;    // read ident/next of current slot
    logic srch_step;  // advance walk
    logic do_reg;     // register at free slot
    logic do_unlink;  // unlink found slot
    logic do_append;  // append found slot to new level
    logic proc_pick;  // choose highest nonempty level
    logic proc_rd;    // read head slot
    logic proc_pop;   // pop head
    logic set_res;    // load result register
    status_t res_st;
    logic res_data;   // result carries id/level
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic lvl_valid;  // new_level below 3
    logic cur_nil;    // walk pointer null
    logic lvl_end;    // walk leaves this level after the current slot
    logic walk_last;  // last level walked
    logic hit;        // ident matches
    logic full;
    logic all_empty;
  } sts_t;

endpackage

[rtl/tplq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplq_datapath
// Slot store, level links, walk pointers and result register.
// ----------------------------------------------------------------------------
module tplq_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tplq_pkg::ctl_t                 ctl,
  output tplq_pkg::sts_t                 sts,
  input  logic [1:0]                     in_cmd,
  input  logic [tplq_pkg::IdW-1:0]       in_id,
  input  logic [1:0]                     in_lvl,
  output logic [tplq_pkg::StatusW-1:0]   res_status,
  output logic [tplq_pkg::IdW-1:0]       res_id,
  output logic [tplq_pkg::LevelW-1:0]    res_level
);

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  logic [tplq_pkg::IdW-1:0] slot_ident [ENTRIES];
  logic [PW-1:0]            slot_next  [ENTRIES];
  logic [ENTRIES-1:0]       used_r, used_nxt;
  logic [PW-1:0]            head_r [3];
  logic [PW-1:0]            tail_r [3];

  logic [1:0]               cmd_r;
  logic [tplq_pkg::IdW-1:0] id_r;
  logic [1:0]               nl_r;
  logic [1:0]               lvl_r;
  logic [PW-1:0]            cur_r, prev_r, steps_r;
  logic [tplq_pkg::IdW-1:0] rd_id_r;
  logic [PW-1:0]            rd_next_r;

  logic [PW-1:0] free_slot;
  logic [1:0]    pick_lvl;
  logic          lvl_end;

  always_comb begin
    free_slot = NIL;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) free_slot = PW'(i);
    end
  end

  always_comb begin
    pick_lvl = 2'd2;
    if (head_r[1] != NIL) pick_lvl = 2'd1;
    if (head_r[0] != NIL) pick_lvl = 2'd0;
  end

  assign lvl_end = (cur_r == NIL) || (steps_r == NIL) || (rd_next_r == NIL) ||
                   (steps_r == NIL - PW'(1));

  assign sts.cmd       = tplq_pkg::cmd_t'(cmd_r);
  assign sts.lvl_valid = (nl_r != 2'd3);
  assign sts.cur_nil   = (cur_r == NIL) || (steps_r == NIL);
  assign sts.lvl_end   = lvl_end;
  assign sts.walk_last = (lvl_r == 2'd2);
  assign sts.hit       = (rd_id_r == id_r);
  assign sts.full      = (free_slot == NIL);
  assign sts.all_empty = (head_r[0] == NIL) && (head_r[1] == NIL) && (head_r[2] == NIL);

  always_comb begin
    used_nxt = used_r;
    if (ctl.do_reg) used_nxt[free_slot[AW-1:0]] = 1'b1;
    if (ctl.proc_pop) used_nxt[cur_r[AW-1:0]] = 1'b0;
  end

  // slot store
  always_ff @(posedge clk) begin
    if (ctl.srch_rd || ctl.proc_rd) begin
      rd_id_r   <= slot_ident[cur_r[AW-1:0]];
      rd_next_r <= slot_next[cur_r[AW-1:0]];
    end
    if (ctl.do_reg) begin
      slot_ident[free_slot[AW-1:0]] <= id_r;
      slot_next[free_slot[AW-1:0]]  <= NIL;
      if (tail_r[2] != NIL) slot_next[tail_r[2][AW-1:0]] <= free_slot;
    end else if (ctl.do_unlink) begin
      if (prev_r != NIL) slot_next[prev_r[AW-1:0]] <= rd_next_r;
    end else if (ctl.do_append) begin
      slot_next[cur_r[AW-1:0]] <= NIL;
      if (tail_r[nl_r] != NIL) slot_next[tail_r[nl_r][AW-1:0]] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      id_r  <= in_id;
      nl_r  <= in_lvl;
      lvl_r <= 2'd0;
    end
    if (ctl.srch_init) begin
      cur_r   <= head_r[lvl_r];
      prev_r  <= NIL;
      steps_r <= '0;
    end
    if (ctl.srch_step) begin
      if (lvl_end) begin
        lvl_r <= lvl_r + 2'd1;
        cur_r <= head_r[lvl_r + 2'd1];
        prev_r <= NIL;
        steps_r <= '0;
      end else begin
        prev_r  <= cur_r;
        cur_r   <= rd_next_r;
        steps_r <= steps_r + PW'(1);
      end
    end
    if (ctl.proc_pick) begin
      lvl_r <= pick_lvl;
      cur_r <= head_r[pick_lvl];
    end
    if (ctl.set_res) begin
      res_status <= ctl.res_st;
      res_id     <= ctl.res_data ? (cmd_r == tplq_pkg::CMD_PROCESS ? rd_id_r : id_r) : '0;
      res_level  <= ctl.res_data ? lvl_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int l = 0; l < 3; l++) begin
        head_r[l] <= NIL;
        tail_r[l] <= NIL;
      end
    end else begin
      used_r <= used_nxt;
      if (ctl.do_reg) begin
        if (tail_r[2] == NIL) head_r[2] <= free_slot;
        tail_r[2] <= free_slot;
      end
      if (ctl.do_unlink) begin
        if (prev_r == NIL) head_r[lvl_r] <= rd_next_r;
        if (tail_r[lvl_r] == cur_r) tail_r[lvl_r] <= prev_r;
      end
      if (ctl.do_append) begin
        if (head_r[nl_r] == NIL || tail_r[nl_r] == NIL) head_r[nl_r] <= cur_r;
        tail_r[nl_r] <= cur_r;
      end
      if (ctl.proc_pop) begin
        head_r[lvl_r] <= rd_next_r;
        if (rd_next_r == NIL) tail_r[lvl_r] <= NIL;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_reg |-> free_slot != NIL) else $error("register without free slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.proc_pop |=> !used_r[$past(cur_r[AW-1:0])]) else $error("pop left slot used");
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r[0] == NIL) |-> (tail_r[0] == NIL)) else $error("level 0 links disagree");

endmodule

[rtl/tplq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplq_ctrl
// Command sequencer: walks levels by id or pops, edits links, posts result.
// ----------------------------------------------------------------------------
module tplq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_fire,
  output logic           busy,
  output logic           res_valid,
  output tplq_pkg::ctl_t ctl,
  input  tplq_pkg::sts_t sts
);

  tplq_pkg::state_t state_r, state_nxt;
  logic found_r, found_nxt;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    unique case (state_r)
      tplq_pkg::S_IDLE: if (in_fire) state_nxt = tplq_pkg::S_DISPATCH;
      tplq_pkg::S_DISPATCH: begin
        found_nxt = 1'b0;
        if (sts.cmd == tplq_pkg::CMD_PROCESS) state_nxt = tplq_pkg::S_PROC;
        else state_nxt = tplq_pkg::S_SRCH_INIT;
      end
      tplq_pkg::S_SRCH_INIT: state_nxt = tplq_pkg::S_SRCH_RD;
      tplq_pkg::S_SRCH_RD: begin
        if (sts.cur_nil && sts.walk_last) state_nxt = tplq_pkg::S_REG;
        else state_nxt = tplq_pkg::S_SRCH_CHK;
      end
      tplq_pkg::S_SRCH_CHK: begin
        if (!sts.cur_nil && sts.hit) begin
          found_nxt = 1'b1;
          state_nxt = tplq_pkg::S_REG;
        end else if (sts.walk_last && sts.lvl_end) begin
          state_nxt = tplq_pkg::S_REG;
        end else state_nxt = tplq_pkg::S_SRCH_RD;
      end
      tplq_pkg::S_REG: begin
        if (sts.cmd == tplq_pkg::CMD_CHANGE && found_r && sts.lvl_valid)
          state_nxt = tplq_pkg::S_UNLINK;
        else state_nxt = tplq_pkg::S_DONE;
      end
      tplq_pkg::S_UNLINK: state_nxt = tplq_pkg::S_APPEND;
      tplq_pkg::S_APPEND: state_nxt = tplq_pkg::S_DONE;
      tplq_pkg::S_PROC: begin
        if (sts.all_empty) state_nxt = tplq_pkg::S_DONE;
        else state_nxt = tplq_pkg::S_PROC_RD;
      end
      tplq_pkg::S_PROC_RD: state_nxt = tplq_pkg::S_PROC_POP;
      tplq_pkg::S_PROC_POP: state_nxt = tplq_pkg::S_DONE;
      tplq_pkg::S_DONE: if (out_fire) state_nxt = tplq_pkg::S_IDLE;
      default: state_nxt = tplq_pkg::S_IDLE;
    endcase
  end

  // walk: SRCH_RD reads the slot, SRCH_CHK compares and steps;
  // when the level ends at SRCH_CHK, step moves to the next level.
  always_comb begin
    ctl = '0;
    ctl.res_st = tplq_pkg::ST_OK;
    busy = (state_r != tplq_pkg::S_IDLE);
    res_valid = (state_r == tplq_pkg::S_DONE);
    unique case (state_r)
      tplq_pkg::S_IDLE: ctl.load = in_fire;
      tplq_pkg::S_SRCH_INIT: ctl.srch_init = 1'b1;
      tplq_pkg::S_SRCH_RD: ctl.srch_rd = !sts.cur_nil;
      tplq_pkg::S_SRCH_CHK:
        ctl.srch_step = !(!sts.cur_nil && sts.hit) && !(sts.walk_last && sts.lvl_end);
      tplq_pkg::S_REG: begin
        ctl.set_res = 1'b1;
        unique case (sts.cmd)
          tplq_pkg::CMD_REGISTER: begin
            if (found_r) ctl.res_st = tplq_pkg::ST_DUP;
            else if (sts.full) ctl.res_st = tplq_pkg::ST_FULL;
            else ctl.do_reg = 1'b1;
          end
          tplq_pkg::CMD_CHANGE: begin
            if (!found_r) ctl.res_st = tplq_pkg::ST_NOTFOUND;
            else if (!sts.lvl_valid) ctl.res_st = tplq_pkg::ST_BADLEVEL;
          end
          tplq_pkg::CMD_LOOKUP: begin
            if (found_r) ctl.res_data = 1'b1;
            else ctl.res_st = tplq_pkg::ST_NOTFOUND;
          end
          default: ctl.res_st = tplq_pkg::ST_OK;
        endcase
      end
      tplq_pkg::S_UNLINK: ctl.do_unlink = 1'b1;
      tplq_pkg::S_APPEND: ctl.do_append = 1'b1;
      tplq_pkg::S_PROC: begin
        ctl.proc_pick = !sts.all_empty;
        ctl.set_res = sts.all_empty;
        ctl.res_st = tplq_pkg::ST_EMPTY;
      end
      tplq_pkg::S_PROC_RD: ctl.proc_rd = 1'b1;
      tplq_pkg::S_PROC_POP: begin
        ctl.proc_pop = 1'b1;
        ctl.set_res = 1'b1;
        ctl.res_data = 1'b1;
      end
      default: ctl.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tplq_pkg::S_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == tplq_pkg::S_DISPATCH) else $error("beat not taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> state_r == tplq_pkg::S_IDLE) else $error("result not retired");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.do_unlink |=> ctl.do_append)) else $error("unlink without append");

endmodule

[rtl/three_level_priority_ticket_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_ticket_queue
// Strict three-level priority queue of unique ticket ids.
// ----------------------------------------------------------------------------
// One command at a time. Register, change level and lookup walk the linked
// levels high, medium, low one slot at a time, reading each slot and then
// comparing it; a change of the last ticket of a full low level makes the
// longest walk. Process next reads and pops the head of the highest nonempty
// level, or answers with empty status when every level is empty. Reading the
// slot store through its one read port paces the walk. The result beat is held
// until taken; the next command is accepted after that.
module three_level_priority_ticket_queue #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command[1:0], ticket_id[32:2], new_level[34:33]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[2:0], result_id[33:3], result_level[35:34]
);

  tplq_pkg::ctl_t ctl;
  tplq_pkg::sts_t sts;
  logic busy, in_fire, out_fire;
  logic [tplq_pkg::StatusW-1:0] res_status;
  logic [tplq_pkg::IdW-1:0]     res_id;
  logic [tplq_pkg::LevelW-1:0]  res_level;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign out_tdata = {4'd0, res_level, res_id, res_status};

  tplq_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .busy,
    .res_valid(out_tvalid), .ctl, .sts
  );

  tplq_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_cmd(in_tdata[1:0]), .in_id(in_tdata[32:2]), .in_lvl(in_tdata[34:33]),
    .res_status, .res_id, .res_level
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-level priority ticket queue: a directed
// table of commands, then random well-formed traffic mostly over a small id
// pool, each result compared with a queue model kept in the bench.
// ----------------------------------------------------------------------------
module tb;

  localparam int Entries   = 16;
  localparam int NumRandom = 800;
  localparam int CycleCap  = 400000;
  localparam int IdW       = tplq_pkg::IdW;
  localparam int LevelW    = tplq_pkg::LevelW;

  typedef struct packed {
    tplq_pkg::cmd_t   cmd;
    logic [IdW-1:0]   id;
    logic [1:0]       lvl;
  } ticket_cmd_t;

  typedef struct packed {
    tplq_pkg::status_t st;
    logic [IdW-1:0]    id;
    logic [LevelW-1:0] lvl;
  } ticket_res_t;

  typedef struct {
    ticket_cmd_t c;
    logic        known;
    ticket_res_t r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  three_level_priority_ticket_queue #(.ENTRIES(Entries)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // queue model: each level an ordered list of ids
  logic [IdW-1:0] lvl_q[3][$];
  ticket_res_t    pending_q[$];
  int             errors = 0;
  int             cycles = 0;
  int             n_out = 0;
  int             st_seen[6];
  bit             stim_done = 1'b0;
  bit             hold_rx = 1'b0;
  logic [IdW-1:0] id_pool[24];

  function automatic int count_held();
    return lvl_q[0].size() + lvl_q[1].size() + lvl_q[2].size();
  endfunction

  function automatic ticket_res_t queue_step(ticket_cmd_t c);
    ticket_res_t r;
    int fl;
    int fi;
    r = '{st: tplq_pkg::ST_OK, id: '0, lvl: '0};
    fl = -1;
    fi = -1;
    if (c.cmd != tplq_pkg::CMD_PROCESS)
      for (int l = 0; l < 3; l++)
        for (int i = 0; i < lvl_q[l].size(); i++)
          if (fl < 0 && lvl_q[l][i] == c.id) begin
            fl = l;
            fi = i;
          end
    case (c.cmd)
      tplq_pkg::CMD_REGISTER: begin
        if (fl >= 0) r.st = tplq_pkg::ST_DUP;
        else if (count_held() >= Entries) r.st = tplq_pkg::ST_FULL;
        else lvl_q[2].push_back(c.id);
      end
      tplq_pkg::CMD_CHANGE: begin
        if (fl < 0) r.st = tplq_pkg::ST_NOTFOUND;
        else if (c.lvl == 2'd3) r.st = tplq_pkg::ST_BADLEVEL;
        else begin
          lvl_q[fl].delete(fi);
          lvl_q[c.lvl].push_back(c.id);
        end
      end
      tplq_pkg::CMD_LOOKUP: begin
        if (fl < 0) r.st = tplq_pkg::ST_NOTFOUND;
        else begin
          r.id = c.id;
          r.lvl = fl[1:0];
        end
      end
      default: begin
        r.st = tplq_pkg::ST_EMPTY;
        for (int l = 0; l < 3; l++)
          if (r.st == tplq_pkg::ST_EMPTY && lvl_q[l].size() > 0) begin
            r.st = tplq_pkg::ST_OK;
            r.id = lvl_q[l].pop_front();
            r.lvl = l[1:0];
          end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH beat %0d %s: got %0h want %0h", n_out, what, got, want);
    errors++;
  endtask

  // valid stays high across back-to-back beats; drop it only for idle cycles
  task automatic send_cmd(ticket_cmd_t c, bit known, ticket_res_t r);
    ticket_res_t p;
    int idle;
    idle = $urandom_range(0, 3);
    if (idle != 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, c.lvl, c.id, c.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = queue_step(c);
    if (known && p != r) report_mismatch("table row", 64'(p), 64'(r));
    pending_q.push_back(p);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ticket_cmd_t mk(tplq_pkg::cmd_t c, logic [IdW-1:0] id, logic [1:0] l);
    return '{cmd: c, id: id, lvl: l};
  endfunction

  function automatic ticket_res_t res(tplq_pkg::status_t s, logic [IdW-1:0] id,
                                      logic [1:0] l);
    return '{st: s, id: id, lvl: l};
  endfunction

  // receiver
  initial begin
    ticket_res_t got;
    ticket_res_t want;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = '{st: tplq_pkg::status_t'(out_tdata[2:0]), id: out_tdata[33:3],
                lvl: out_tdata[35:34]};
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected beat", 64'(got), 64'd0);
        end else begin
          want = pending_q.pop_front();
          if (got.st != want.st) report_mismatch("status", 64'(got.st), 64'(want.st));
          if (got.id != want.id) report_mismatch("result_id", 64'(got.id), 64'(want.id));
          if (got.lvl != want.lvl)
            report_mismatch("result_level", 64'(got.lvl), 64'(want.lvl));
          if (want.st <= tplq_pkg::ST_BADLEVEL) st_seen[want.st]++;
        end
        n_out++;
      end
      out_tready <= hold_rx ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("** three_level_priority_ticket_queue: FAILED **");
      $finish;
    end
  end

  // long receiver hold-off, counted in its own process
  initial begin
    wait (stim_done == 1'b0 && n_out > 40);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    dir_row_t    tbl[$];
    ticket_cmd_t c;
    int          k;
    logic [IdW-1:0] maxid;
    maxid = {IdW{1'b1}};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tbl.push_back('{mk(tplq_pkg::CMD_PROCESS, 0, 0), 1, res(tplq_pkg::ST_EMPTY, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_LOOKUP, 0, 0), 1, res(tplq_pkg::ST_NOTFOUND, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_CHANGE, 5, 0), 1, res(tplq_pkg::ST_NOTFOUND, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_REGISTER, 0, 0), 1, res(tplq_pkg::ST_OK, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_REGISTER, maxid, 3), 1, res(tplq_pkg::ST_OK, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_REGISTER, maxid, 0), 1, res(tplq_pkg::ST_DUP, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_LOOKUP, maxid, 0), 1, res(tplq_pkg::ST_OK, maxid, 2)});
    tbl.push_back('{mk(tplq_pkg::CMD_CHANGE, maxid, 3), 1,
                    res(tplq_pkg::ST_BADLEVEL, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_CHANGE, maxid, 0), 1, res(tplq_pkg::ST_OK, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_CHANGE, 0, 1), 1, res(tplq_pkg::ST_OK, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_CHANGE, 0, 1), 0, res(tplq_pkg::ST_OK, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_LOOKUP, 0, 0), 1, res(tplq_pkg::ST_OK, 0, 1)});
    tbl.push_back('{mk(tplq_pkg::CMD_PROCESS, 0, 0), 1, res(tplq_pkg::ST_OK, maxid, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_PROCESS, 0, 0), 1, res(tplq_pkg::ST_OK, 0, 1)});
    tbl.push_back('{mk(tplq_pkg::CMD_PROCESS, 0, 0), 1, res(tplq_pkg::ST_EMPTY, 0, 0)});
    for (int i = 0; i < Entries; i++)
      tbl.push_back('{mk(tplq_pkg::CMD_REGISTER, 31'h5555_0000 + IdW'(i), 2), 0,
                      res(tplq_pkg::ST_OK, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_REGISTER, 31'h2aaa_aaaa, 1), 1,
                    res(tplq_pkg::ST_FULL, 0, 0)});
    tbl.push_back('{mk(tplq_pkg::CMD_REGISTER, 31'h5555_0003, 0), 1,
                    res(tplq_pkg::ST_DUP, 0, 0)});
    foreach (tbl[i]) send_cmd(tbl[i].c, tbl[i].known, tbl[i].r);

    foreach (id_pool[i]) id_pool[i] = IdW'($urandom()) & maxid;
    id_pool[0] = 0;
    id_pool[1] = maxid;
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        idle_input();
        while (pending_q.size() != 0) @(posedge clk);
      end
      k = $urandom_range(0, 99);
      if (k < 4) c = mk(tplq_pkg::cmd_t'($urandom_range(0, 3)), IdW'($urandom()) & maxid,
                        2'($urandom_range(0, 3)));
      else begin
        c.cmd = tplq_pkg::cmd_t'($urandom_range(0, 3));
        if (c.cmd == tplq_pkg::CMD_REGISTER && $urandom_range(0, 2) == 0)
          c.cmd = tplq_pkg::CMD_PROCESS;
        c.id = id_pool[$urandom_range(0, 23)];
        c.lvl = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      end
      send_cmd(c, 1'b0, res(tplq_pkg::ST_OK, 0, 0));
    end
    idle_input();
    stim_done = 1'b1;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d results: ok %0d dup %0d notfound %0d full %0d empty %0d",
             n_out, st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    $display("bad level %0d, with a long output stall and a drain pause", st_seen[5]);
    if (errors == 0)
      $display("** three_level_priority_ticket_queue: PASSED **");
    else
      $display("** three_level_priority_ticket_queue: FAILED **");
    $finish;
  end

endmodule
